// ===== hdl/bas_pkg.sv =====
// ---------------------------------------------------------------------------
// Breakpoint axis search: shared types and constants
// Field widths, item kinds and clamp status codes of the lookup block.
// ---------------------------------------------------------------------------
package bas_pkg;

  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned COUNT_W = 7;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_ABOVE = 2'd1,
    CLAMP_BELOW = 2'd2
  } clamp_e;

endpackage

// ===== hdl/breakpoint_axis_search_fraction.sv =====
// Sequence: a write word is stored from idle; a lookup checks the top breakpoint, clamps
// high or walks the table backward to clamp low or to find segment k, then runs the
// divider and passes the result to the output register.
// Throughput: one lookup at a time, set by the single-port table walk and the
// 16-step restoring divider; a result may wait in the output register.
// Reset: asynchronous, active low; point count returns to 1, table is not cleared.
// ---------------------------------------------------------------------------
// Breakpoint axis search with interpolation fraction
// Walks a breakpoint table backward to find the segment holding a sample and
// divides its offset by the segment width into an unsigned Q0.16 fraction.
// ---------------------------------------------------------------------------
module breakpoint_axis_search_fraction
  import bas_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,   // point_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,  // entry_index, entry_value, sample, zero pad
  input  logic               s_axis_tuser,  // mode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // segment_index, fraction, zero pad
  output logic [1:0]         m_axis_tuser   // clamp_status
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned N_W   = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_WALK,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     k_q, k_d;
  logic [VALUE_W-1:0]   x_q, x_d;
  logic [VALUE_W-1:0]   hi_q, hi_d;
  logic [VALUE_W-1:0]   rem_q, rem_d;
  logic [VALUE_W-1:0]   div_q, div_d;
  logic [FRAC_W-1:0]    quo_q, quo_d;
  logic [3:0]           step_q, step_d;
  clamp_e               stat_q, stat_d;
  logic [COUNT_W-1:0]   cnt_q;
  logic                 ovld_q, ovld_d;
  logic [SLOT_W-1:0]    oidx_q, oidx_d;
  logic [FRAC_W-1:0]    ofrac_q, ofrac_d;
  clamp_e               ostat_q, ostat_d;

  logic [VALUE_W-1:0]   mem_q [MAX_POINTS];
  logic [VALUE_W-1:0]   rdata_q;

  logic                 in_acc;
  logic                 wr_en;
  logic [SLOT_W-1:0]    in_slot;
  logic [VALUE_W-1:0]   in_value;
  logic [VALUE_W-1:0]   in_sample;
  logic [N_W-1:0]       n_pts;
  logic [IDX_W-1:0]     top_idx;
  logic                 x_lt;
  logic [VALUE_W:0]     num_full;
  logic [VALUE_W:0]     wid_full;
  logic [VALUE_W:0]     rem2;
  logic [VALUE_W+1:0]   diff;
  logic                 ge;

  assign in_slot   = s_axis_tdata[5:0];
  assign in_value  = s_axis_tdata[21:6];
  assign in_sample = s_axis_tdata[37:22];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_acc && (s_axis_tuser == MODE_WRITE)
                         && (32'(in_slot) < MAX_POINTS);

  always_comb begin
    if (cnt_q == '0) begin
      n_pts = N_W'(1);
    end else if (32'(cnt_q) > MAX_POINTS) begin
      n_pts = N_W'(MAX_POINTS);
    end else begin
      n_pts = N_W'(cnt_q);
    end
  end
  assign top_idx = IDX_W'(n_pts - N_W'(1));

  assign x_lt     = $signed(x_q) < $signed(rdata_q);
  assign num_full = {x_q[VALUE_W-1], x_q} - {rdata_q[VALUE_W-1], rdata_q};
  assign wid_full = {hi_q[VALUE_W-1], hi_q} - {rdata_q[VALUE_W-1], rdata_q};
  assign rem2     = {rem_q, 1'b0};
  assign diff     = {1'b0, rem2} - {2'b00, div_q};
  assign ge       = !diff[VALUE_W+1];

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    x_d     = x_q;
    hi_d    = hi_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    step_d  = step_q;
    stat_d  = stat_q;
    ovld_d  = ovld_q && !m_axis_tready;
    oidx_d  = oidx_q;
    ofrac_d = ofrac_q;
    ostat_d = ostat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == MODE_LOOKUP)) begin
          x_d     = in_sample;
          k_d     = top_idx;
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        quo_d = '0;
        if (!x_lt) begin
          stat_d  = CLAMP_ABOVE;
          state_d = ST_FIN;
        end else if (k_q == '0) begin
          stat_d  = CLAMP_BELOW;
          state_d = ST_FIN;
        end else begin
          hi_d    = rdata_q;
          k_d     = k_q - IDX_W'(1);
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (x_lt) begin
          if (k_q == '0) begin
            quo_d   = '0;
            stat_d  = CLAMP_BELOW;
            state_d = ST_FIN;
          end else begin
            hi_d = rdata_q;
            k_d  = k_q - IDX_W'(1);
          end
        end else begin
          rem_d   = num_full[VALUE_W-1:0];
          div_d   = wid_full[VALUE_W-1:0];
          quo_d   = '0;
          step_d  = '0;
          stat_d  = CLAMP_NONE;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? diff[VALUE_W-1:0] : rem2[VALUE_W-1:0];
        quo_d  = {quo_q[FRAC_W-2:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          oidx_d  = SLOT_W'(k_q);
          ofrac_d = quo_q;
          ostat_d = stat_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      x_q     <= '0;
      hi_q    <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      quo_q   <= '0;
      step_q  <= '0;
      stat_q  <= CLAMP_NONE;
      ovld_q  <= 1'b0;
      oidx_q  <= '0;
      ofrac_q <= '0;
      ostat_q <= CLAMP_NONE;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      x_q     <= x_d;
      hi_q    <= hi_d;
      rem_q   <= rem_d;
      div_q   <= div_d;
      quo_q   <= quo_d;
      step_q  <= step_d;
      stat_q  <= stat_d;
      ovld_q  <= ovld_d;
      oidx_q  <= oidx_d;
      ofrac_q <= ofrac_d;
      ostat_q <= ostat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(in_slot)] <= in_value;
    end
    rdata_q <= mem_q[k_d];
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, ofrac_q, oidx_q};
  assign m_axis_tuser  = ostat_q;

`ifndef SYNTHESIS
  a_div_rem_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below segment width");

  a_clamp_zero_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != CLAMP_NONE)) |-> (m_axis_tdata[21:6] == '0))
    else $error("clamped result with non-zero fraction");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result word raised outside the finish step");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Breakpoint axis search testbench
// Loads breakpoint tables of many point counts and shapes, looks up samples
// on and around randomly chosen breakpoints and past both ends, and checks each result
// word against an in-bench search-and-divide predictor. Sender bursts and
// receiver stalls vary throughout, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import bas_pkg::*;

  localparam int AXIS_DEPTH = 64;

  typedef struct packed {
    logic       mode;
    logic [5:0]  slot;
    logic [15:0] value;
    logic [15:0] sample;
  } word_t;

  typedef struct packed {
    logic [5:0]  seg;
    logic [15:0] frac;
    clamp_e      status;
  } result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [6:0]  cfg_wdata_i   = 7'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // entry_index, entry_value, sample, zero pad
  logic        s_axis_tuser  = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // segment_index, fraction, zero pad
  logic [1:0]  m_axis_tuser;         // clamp_status

  breakpoint_axis_search_fraction #(
    .MAX_POINTS(AXIS_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  word_t   words_to_send [$];
  result_t due_results [$];
  word_t   word_on_bus;
  result_t head;

  int axis_model [AXIS_DEPTH];
  int count_model = 1;
  int plan_axis [AXIS_DEPTH];

  int errors        = 0;
  int words_queued  = 0;
  int writes_done   = 0;
  int lookups_done  = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int inside_hits   = 0;
  int high_hits     = 0;
  int low_hits      = 0;

  int burst_left = 1;
  int gap_left   = 0;
  bit offer;
  int stall_style = 0;
  int style_left  = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  int count_plan [10] = '{64, 2, 5, 127, 0, 3, 1, 8, 100, 4};

  function automatic int points_in_use(input int cnt);
    return (cnt == 0) ? 1 : ((cnt > AXIS_DEPTH) ? AXIS_DEPTH : cnt);
  endfunction

  function automatic int sat16(input int v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  // Walk down from the second-last breakpoint to the segment holding the sample
  function automatic result_t locate_sample(input logic [15:0] smp);
    int      n;
    int      k;
    int      x;
    longint  num;
    longint  span;
    longint  q;
    result_t r;
    n        = points_in_use(count_model);
    x        = int'($signed(smp));
    r.seg    = '0;
    r.frac   = '0;
    r.status = CLAMP_BELOW;
    if (x >= axis_model[n-1]) begin
      r.seg    = 6'(n - 1);
      r.status = CLAMP_ABOVE;
      return r;
    end
    if (n == 1) return r;
    k = n - 2;
    while (k >= 0 && x < axis_model[k]) k--;
    if (k < 0) return r;
    num  = longint'(x) - longint'(axis_model[k]);
    span = longint'(axis_model[k+1]) - longint'(axis_model[k]);
    q    = (span == 0) ? 0 : (num << 16) / span;
    r.seg    = 6'(k);
    r.frac   = 16'((q > 65535) ? 65535 : q);
    r.status = CLAMP_NONE;
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic send_write(input int slot, input int value);
    word_t w;
    w.mode   = MODE_WRITE;
    w.slot   = 6'(slot);
    w.value  = 16'(value);
    w.sample = 16'($urandom);
    words_to_send.push_back(w);
    plan_axis[slot] = value;
    words_queued++;
  endtask

  task automatic send_lookup(input int smp);
    word_t w;
    w.mode   = MODE_LOOKUP;
    w.slot   = 6'($urandom);
    w.value  = 16'($urandom);
    w.sample = 16'(smp);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  function automatic int pick_sample(input int n);
    int i;
    int lo;
    int hi;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return plan_axis[i];
      3: return sat16(plan_axis[i] - 1);
      4: return sat16(plan_axis[i] + 1);
      5: return int'($signed(16'($urandom)));
      default: begin
        if (i == n - 1) return plan_axis[i];
        lo = plan_axis[i];
        hi = plan_axis[i+1];
        if (hi > lo) return lo + int'($urandom_range(0, hi - lo - 1));
        return lo;
      end
    endcase
  endfunction

  // Shapes: 0 spread ascending, 1 tight with repeats, 2 full span, 3 unordered
  task automatic fill_axis(input int n, input int shape);
    int v;
    int step_max;
    int i;
    v        = (shape == 2) ? -32768 : -32768 + int'($urandom_range(0, 30000));
    step_max = (n > 1) ? (32767 - v) / (n - 1) : 1;
    for (i = 0; i < n; i++) begin
      if (shape == 3) begin
        send_write(i, int'($signed(16'($urandom))));
      end else begin
        if (shape == 2 && i == n - 1 && n > 1) v = 32767;
        send_write(i, v);
        v = v + ((shape == 1) ? int'($urandom_range(0, 3)) : int'($urandom_range(1, step_max)));
      end
    end
  endtask

  // Hold until every word is in and every result out, then let the block settle
  task automatic settle();
    @(negedge clk_i);
    while (words_to_send.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_count(input int v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 7'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_model = v;
    settings_used++;
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Driver: bursts of words with random gaps; accepted writes update the model, lookups queue results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (word_on_bus.mode == MODE_WRITE) begin
          axis_model[word_on_bus.slot] = int'($signed(word_on_bus.value));
          writes_done++;
        end else begin
          due_results.push_back(locate_sample(word_on_bus.sample));
          lookups_done++;
        end
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (words_to_send.size() != 0) begin
          word_on_bus = words_to_send.pop_front();
          s_axis_tdata <= {2'b00, word_on_bus.sample, word_on_bus.value, word_on_bus.slot};
          s_axis_tuser <= word_on_bus.mode;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 6);
              default: gap_left = $urandom_range(7, 40);
            endcase
          end
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // Monitor: check each result word, stall on a pattern of its own
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual seg %0d frac %0d status %0d",
                 $time, m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tuser);
      end else begin
        head = due_results.pop_front();
        check_field("segment_index", head.seg, m_axis_tdata[5:0]);
        check_field("fraction", head.frac, m_axis_tdata[21:6]);
        check_field("clamp_status", head.status, m_axis_tuser);
        case (head.status)
          CLAMP_NONE:  inside_hits++;
          CLAMP_ABOVE: high_hits++;
          default:     low_hits++;
        endcase
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 60 && words_to_send.size() > 20) begin
      hold_done = 1'b1;
      hold_left = 500;
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left  = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      case (stall_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #12_000_000;
    $display("breakpoint_axis_search_fraction verification failed");
    $finish;
  end

  initial begin
    int phase;
    int cnt;
    int n;
    int reps;
    int i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Single point at reset count, extreme slots and values
    send_write(0, 100);
    send_write(63, 32767);
    send_write(62, -32768);
    send_lookup(100);
    send_lookup(32767);
    send_lookup(99);
    send_lookup(-32768);
    settle();

    set_count(4);
    send_write(0, -32768);
    send_write(1, -10);
    send_write(2, 10);
    send_write(3, 32767);
    send_lookup(-32768);
    send_lookup(-11);
    send_lookup(0);
    send_lookup(32766);
    send_lookup(32767);
    send_lookup(-10);
    // Raise the first breakpoint to reach the low clamp
    send_write(0, -20000);
    send_lookup(-20001);
    send_lookup(-32768);
    settle();

    set_count(0);
    send_lookup(-20000);
    send_lookup(-30000);

    phase = 0;
    while (words_queued < 620) begin
      settle();
      if (phase < 10) cnt = count_plan[phase];
      else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(0, 127);
      else cnt = $urandom_range(1, 8);
      set_count(cnt);
      n = points_in_use(cnt);
      fill_axis(n, ($urandom_range(0, 9) < 6) ? 0 : int'($urandom_range(1, 3)));
      reps = $urandom_range(20, 50);
      for (i = 0; i < reps; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_write($urandom_range(0, AXIS_DEPTH - 1), int'($signed(16'($urandom))));
        else
          send_lookup(pick_sample(n));
      end
      phase++;
    end
    settle();

    $display("Run covered %0d words: %0d breakpoint writes, %0d lookups, %0d point-count settings",
             writes_done + lookups_done, writes_done, lookups_done, settings_used);
    $display("Lookups: %0d inside a segment, %0d clamped high, %0d clamped low or single point",
             inside_hits, high_hits, low_hits);
    if (errors == 0 && due_results.size() == 0) begin
      $display("breakpoint_axis_search_fraction verification clean");
    end else begin
      $display("breakpoint_axis_search_fraction verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bas_pkg.sv
hdl/breakpoint_axis_search_fraction.sv
test/testbench.sv
